### src/mhsi_pkg.sv
// ----------------------------------------------------------------------------
// Magnetometer calibration package
// Shared types and constants for the hard/soft-iron calibration core.
// ----------------------------------------------------------------------------
package mhsi_pkg;

  typedef enum logic [1:0] {
    OP_COLLECT  = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_APPLY    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_BIAS   = 3'd0,
    REG_ROW_X  = 3'd1,
    REG_ROW_Y  = 3'd2,
    REG_ROW_Z  = 3'd3,
    REG_ENABLE = 3'd4,
    REG_MINS   = 3'd5
  } reg_idx_t;

  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int COUNT_W    = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } exec_state_t;

endpackage

### src/mhsi_if.sv
// ----------------------------------------------------------------------------
// Magnetometer calibration stream interface
// Valid/ready channel carrying an operation and three axis values.
// ----------------------------------------------------------------------------
interface mhsi_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;
  modport source (output valid, operation, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, operation, sample_x, sample_y, sample_z, output ready);
endinterface

interface mhsi_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          corrected;
  logic signed [SAMPLE_BITS-1:0] out_x;
  logic signed [SAMPLE_BITS-1:0] out_y;
  logic signed [SAMPLE_BITS-1:0] out_z;
  modport source (output valid, status, corrected, out_x, out_y, out_z, input ready);
  modport sink (input valid, status, corrected, out_x, out_y, out_z, output ready);
endinterface

### src/mag_hard_soft_iron_calibration_core.sv
// ----------------------------------------------------------------------------
// Magnetometer hard/soft-iron calibration core
// Min/max collection, finalize with serial divider, 3x3 correction.
// ----------------------------------------------------------------------------
// A collect or an unused code is answered from the idle state; apply with valid
// coefficients runs three multiply/accumulate passes of one shared product row;
// a successful finalize runs a one-bit-per-cycle restoring divider once per axis.
// A two-beat queue in front accepts beats while the unit works.
module mag_hard_soft_iron_calibration_core #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mhsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mhsi_pkg::CFG_DATA_W-1:0]   cfg_data,
  mhsi_in_if.sink                           in_ch,
  mhsi_out_if.source                        out_ch
);
  import mhsi_pkg::*;

  logic                     q_valid, q_pop;
  logic [1:0]               q_op;
  logic [3*SAMPLE_BITS-1:0] q_smp;

  mhsi_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_pop, .q_op, .q_smp
  );

  mhsi_exec #(.SAMPLE_BITS(SAMPLE_BITS), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_exec (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_pop, .q_op, .q_smp, .out_ch
  );

endmodule

### src/mhsi_front.sv
// ----------------------------------------------------------------------------
// Calibration front end
// Accepts beats into a two-entry queue that feeds the execution unit.
// ----------------------------------------------------------------------------
module mhsi_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mhsi_in_if.sink                       in_ch,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic [1:0]                    q_op,
  output logic [3*SAMPLE_BITS-1:0]      q_smp
);
  import mhsi_pkg::*;

  localparam int EW = 2 + 3*SAMPLE_BITS;

  logic [EW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign {q_op, q_smp} = mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {in_ch.operation, in_ch.sample_z, in_ch.sample_y, in_ch.sample_x};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_ch.ready) else $error("full queue accepts");
`endif

endmodule

### src/mhsi_exec.sv
// ----------------------------------------------------------------------------
// Calibration execution unit
// Tracks min/max, finalizes with a serial divider and applies correction.
// ----------------------------------------------------------------------------
module mhsi_exec #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mhsi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mhsi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  logic [1:0]                           q_op,
  input  logic [3*SAMPLE_BITS-1:0]             q_smp,
  mhsi_out_if.source                           out_ch
);
  import mhsi_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int GB  = GAIN_FRAC_BITS + 2;
  localparam int RW  = SB + 1;              // range width (unsigned)
  localparam int SW  = RW + 2;              // sum of three ranges
  localparam int NW  = SW + GAIN_FRAC_BITS; // dividend width
  localparam int DW  = RW + 2;              // 3*range width
  localparam int PW  = SB + 1 + GB;         // one product
  localparam int AW  = PW + 2;              // sum of three products
  localparam int DIVC_W = $clog2(NW + 1);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [GB-1:0] GMAX = {1'b0, {(GB-1){1'b1}}};
  localparam logic [GB-1:0] GONE = GB'(1) << GAIN_FRAC_BITS;

  // Configuration registers.
  logic [3*SB-1:0] man_bias_r;
  logic [3*GB-1:0] man_row_r [3];
  logic            man_en_r;
  logic [COUNT_W-1:0] min_smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      man_bias_r   <= '0;
      man_row_r[0] <= (3*GB)'(GONE);
      man_row_r[1] <= (3*GB)'(GONE) << GB;
      man_row_r[2] <= (3*GB)'(GONE) << (2*GB);
      man_en_r     <= 1'b0;
      min_smp_r    <= COUNT_W'(40);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIAS:   man_bias_r   <= cfg_data[3*SB-1:0];
        REG_ROW_X:  man_row_r[0] <= cfg_data[3*GB-1:0];
        REG_ROW_Y:  man_row_r[1] <= cfg_data[3*GB-1:0];
        REG_ROW_Z:  man_row_r[2] <= cfg_data[3*GB-1:0];
        REG_ENABLE: man_en_r     <= cfg_data[0];
        REG_MINS:   min_smp_r    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Calibration state.
  logic signed [SB-1:0] amin_r [3], amax_r [3];
  logic signed [SB-1:0] obias_r [3];
  logic [GB-1:0]        ogain_r [3];
  logic                 seen_r, oval_r;
  logic [COUNT_W-1:0]   cnt_r;

  // Working registers.
  exec_state_t          st_r, st_nxt;
  logic [1:0]           ax_r;
  logic [NW-1:0]        quo_r;
  logic [DW:0]          rem_r;
  logic [DIVC_W-1:0]    dcnt_r;
  logic [SW-1:0]        sum_r;
  logic [RW-1:0]        rng_r [3];
  logic signed [PW-1:0] prod_r [3];
  logic signed [SB:0]   d_r [3];
  logic signed [SB-1:0] res_r [3];
  logic                 ov_r, os_r, oc_r;
  logic                 ov_nxt;
  logic signed [SB-1:0] ox_r, oy_r, oz_r;

  logic signed [SB-1:0] s [3];
  assign s[0] = q_smp[SB-1:0];
  assign s[1] = q_smp[2*SB-1:SB];
  assign s[2] = q_smp[3*SB-1:2*SB];

  logic out_free;
  assign out_free = !ov_r || out_ch.ready;

  assign out_ch.valid     = ov_r;
  assign out_ch.status    = os_r;
  assign out_ch.corrected = oc_r;
  assign out_ch.out_x     = ox_r;
  assign out_ch.out_y     = oy_r;
  assign out_ch.out_z     = oz_r;

  // Combinational helpers.
  logic [DW-1:0]   divisor;
  logic [DW:0]     rem_sh;
  logic            fin_ok;
  logic signed [SB:0] span [3];
  logic [RW-1:0]   rng_c [3];
  logic signed [GB-1:0] mrow [3];
  logic signed [AW-1:0] acc_c;

  always_comb begin
    divisor = DW'(rng_r[ax_r]) + (DW'(rng_r[ax_r]) << 1);
    rem_sh  = {rem_r[DW-1:0], quo_r[NW-1]};
    fin_ok  = seen_r && (cnt_r >= min_smp_r);
    for (int i = 0; i < 3; i++) begin
      span[i]  = (SB+1)'(amax_r[i]) - (SB+1)'(amin_r[i]);
      rng_c[i] = (span[i] <= 0) ? RW'(1) : RW'(span[i]);
    end
    for (int j = 0; j < 3; j++) begin
      mrow[j] = oval_r ? ((ax_r == 2'(j)) ? ogain_r[ax_r] : '0)
                       : man_row_r[ax_r][j*GB +: GB];
    end
    acc_c = AW'(prod_r[0]) + AW'(prod_r[1]) + AW'(prod_r[2])
          + (AW'(1) <<< (GAIN_FRAC_BITS-1));
  end

  // Sequencer next state.
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    case (st_r)
      ST_IDLE: if (q_valid && out_free) begin
        q_pop = 1'b1;
        if (q_op == OP_FINALIZE && fin_ok) st_nxt = ST_DIV;
        else if (q_op == OP_APPLY && (oval_r || man_en_r)) st_nxt = ST_MUL;
      end
      ST_DIV: if (dcnt_r == '0 && ax_r == 2'd2) st_nxt = ST_IDLE;
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: st_nxt = (ax_r == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT: if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // Output valid: cleared when the beat is taken, set when a result is loaded.
  always_comb begin
    ov_nxt = ov_r && !out_ch.ready;
    case (st_r)
      ST_IDLE: if (q_pop && !(q_op == OP_FINALIZE && fin_ok) &&
                   !(q_op == OP_APPLY && (oval_r || man_en_r))) ov_nxt = 1'b1;
      ST_DIV:  if (dcnt_r == '0 && ax_r == 2'd2) ov_nxt = 1'b1;
      ST_OUT:  if (out_free) ov_nxt = 1'b1;
      default: ;
    endcase
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      oval_r <= 1'b0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
      ax_r   <= 2'd0;
      dcnt_r <= '0;
      for (int i = 0; i < 3; i++) begin
        obias_r[i] <= '0;
        ogain_r[i] <= GONE;
      end
    end else begin
      ov_r <= ov_nxt;
      case (st_r)
        ST_IDLE: if (q_pop) begin
          ax_r <= 2'd0;
          case (q_op)
            OP_COLLECT: begin
              seen_r <= 1'b1;
              if (!seen_r) cnt_r <= COUNT_W'(1);
              else if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
            end
            OP_FINALIZE: if (fin_ok) begin
              for (int i = 0; i < 3; i++)
                obias_r[i] <= SB'((SB+1)'(amax_r[i]) + (SB+1)'(amin_r[i]) >>> 1);
              dcnt_r <= DIVC_W'(NW);
            end
            default: ;
          endcase
          if (!(q_op == OP_FINALIZE && fin_ok) &&
              !(q_op == OP_APPLY && (oval_r || man_en_r))) begin
            os_r <= (q_op == OP_FINALIZE);
            oc_r <= 1'b0;
            if (q_op == OP_APPLY) begin
              ox_r <= s[0]; oy_r <= s[1]; oz_r <= s[2];
            end else begin
              ox_r <= '0; oy_r <= '0; oz_r <= '0;
            end
          end
        end
        ST_DIV: begin
          if (dcnt_r == '0) begin
            ogain_r[ax_r] <= (quo_r > NW'(GMAX)) ? GMAX : quo_r[GB-1:0];
            if (ax_r == 2'd2) begin
              oval_r <= 1'b1;
              os_r <= 1'b0; oc_r <= 1'b0;
              ox_r <= '0; oy_r <= '0; oz_r <= '0;
            end else begin
              ax_r   <= ax_r + 2'd1;
              dcnt_r <= DIVC_W'(NW);
            end
          end else begin
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        ST_ACC: ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        ST_OUT: if (out_free) begin
          os_r <= 1'b0; oc_r <= 1'b1;
          ox_r <= res_r[0]; oy_r <= res_r[1]; oz_r <= res_r[2];
        end
        default: ;
      endcase
    end
  end

  // Datapath: min/max, divider, matrix products.
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: if (q_pop) begin
        if (q_op == OP_COLLECT) begin
          for (int i = 0; i < 3; i++) begin
            if (!seen_r || s[i] < amin_r[i]) amin_r[i] <= s[i];
            if (!seen_r || s[i] > amax_r[i]) amax_r[i] <= s[i];
          end
        end
        for (int i = 0; i < 3; i++) begin
          rng_r[i] <= rng_c[i];
          d_r[i] <= (SB+1)'(s[i]) - (SB+1)'(oval_r ? obias_r[i]
                                                 : $signed(man_bias_r[i*SB +: SB]));
        end
        sum_r <= SW'(rng_c[0]) + SW'(rng_c[1]) + SW'(rng_c[2]);
        quo_r <= NW'(SW'(rng_c[0]) + SW'(rng_c[1]) + SW'(rng_c[2])) << GAIN_FRAC_BITS;
        rem_r <= '0;
      end
      ST_DIV: begin
        if (dcnt_r == '0) begin
          quo_r <= NW'(sum_r) << GAIN_FRAC_BITS;
          rem_r <= '0;
        end else if (rem_sh >= (DW+1)'(divisor)) begin
          rem_r <= rem_sh - (DW+1)'(divisor);
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
      end
      ST_MUL: for (int j = 0; j < 3; j++) prod_r[j] <= mrow[j] * d_r[j];
      ST_ACC: begin
        res_r[ax_r] <= ((acc_c >>> GAIN_FRAC_BITS) > AW'(SMAX)) ? SMAX :
                       ((acc_c >>> GAIN_FRAC_BITS) < AW'(SMIN)) ? SMIN :
                       SB'(acc_c >>> GAIN_FRAC_BITS);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> (ov_r && $stable({os_r, oc_r, ox_r, oy_r, oz_r})))
    else $error("result changed while waiting");
  a_idle_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE)) else $error("pop while busy");
  a_div_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> fin_ok) else $error("divide without data");
`endif

endmodule
